FILE: rtl/frequency_threshold_filter_top_defines.svh
// Assertion macros for the frequency threshold filter.
// Compiled out when SYNTHESIS is defined.
`ifndef FREQUENCY_THRESHOLD_FILTER_TOP_DEFINES_SVH
`define FREQUENCY_THRESHOLD_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define FTF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FTF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define FTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: rtl/ftf_pkg.sv
package ftf_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int FILL_W = $clog2(MAX_ITEMS + 1);
    localparam int VALUE_W = 32;
    localparam int CNT_W = 7;
    localparam logic [CNT_W-1:0] RESET_MIN_COUNT = 7'd3;

    typedef enum logic [5:0] {
        ST_LOAD   = 6'b000001,
        ST_FETCH  = 6'b000010,
        ST_LATCH  = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_DECIDE = 6'b010000,
        ST_FINISH = 6'b100000
    } ftf_state_t;

    typedef struct packed {
        logic load;    // store accepted item
        logic fetch;   // read candidate at emit index
        logic latch;   // capture candidate, start scan
        logic scan;    // compare one stored entry
        logic decide;  // threshold check, advance emit index
        logic finish;  // push final result, clear the set
    } ftf_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic i_last;
        logic keep;
        logic pend_valid;
        logic out_free;
    } ftf_stat_t;

endpackage

FILE: rtl/ftf_ram.sv
module ftf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/ftf_ctrl.sv
module ftf_ctrl import ftf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_last_item,
    output logic      s_ready,
    input  ftf_stat_t stat,
    output ftf_cmd_t  cmd
);

    ftf_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid && s_last_item) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_LATCH;
            end
            ST_LATCH: begin
                cmd.latch  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // a new survivor displaces the pending one into the output reg
                if (!(stat.keep && stat.pend_valid) || stat.out_free) begin
                    cmd.decide = 1'b1;
                    state_next = stat.i_last ? ST_FINISH : ST_FETCH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

FILE: rtl/ftf_dpath.sv
module ftf_dpath import ftf_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ftf_cmd_t                  cmd,
    output ftf_stat_t                 stat,
    input  logic signed [VALUE_W-1:0] s_value,
    input  logic                      cfg_wr_en,
    input  logic [CNT_W-1:0]          cfg_wr_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_kept_value,
    output logic                      m_last_result,
    output logic                      m_empty_res,
    output logic                      m_overflow
);

    logic [FILL_W-1:0]         fill_reg;
    logic                      ovf_reg;
    logic [FILL_W-1:0]         i_reg;
    logic [FILL_W-1:0]         j_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          min_count_reg;
    logic signed [VALUE_W-1:0] cand_reg;
    logic signed [VALUE_W-1:0] pend_reg;
    logic                      pend_valid_reg;

    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      out_last_reg;
    logic                      out_empty_reg;
    logic                      out_ovf_reg;

    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [VALUE_W-1:0]        ram_rdata;
    logic                      match;
    logic                      keep;
    logic                      out_free;
    logic                      push_mid;

    assign ram_we   = cmd.load && (fill_reg < FILL_W'(MAX_ITEMS));
    assign match    = (ram_rdata == cand_reg);
    assign keep     = (cnt_reg >= min_count_reg);
    assign out_free = !out_valid_reg || m_ready;
    assign push_mid = cmd.decide && keep && pend_valid_reg;

    always_comb begin
        if (cmd.fetch) begin
            ram_raddr = i_reg[ADDR_W-1:0];
        end else if (cmd.scan) begin
            ram_raddr = j_reg[ADDR_W-1:0];
        end else begin
            ram_raddr = '0;
        end
    end

    ftf_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ITEMS)
    ) u_value_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (s_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            ovf_reg        <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            min_count_reg  <= RESET_MIN_COUNT;
        end else begin
            if (cfg_wr_en) begin
                min_count_reg <= cfg_wr_data;
            end
            if (cmd.load) begin
                if (ram_we) begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.latch) begin
                j_reg <= FILL_W'(1);
            end else if (cmd.scan && !stat.scan_last) begin
                j_reg <= j_reg + FILL_W'(1);
            end
            if (cmd.decide) begin
                i_reg <= i_reg + FILL_W'(1);
                if (keep) begin
                    pend_valid_reg <= 1'b1;
                end
            end
            if (cmd.finish) begin
                fill_reg       <= '0;
                ovf_reg        <= 1'b0;
                i_reg          <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (push_mid || cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            cand_reg <= ram_rdata;
            cnt_reg  <= '0;
        end else if (cmd.scan) begin
            cnt_reg <= cnt_reg + CNT_W'(match);
        end
        if (cmd.decide && keep) begin
            pend_reg <= cand_reg;
        end
        if (push_mid) begin
            out_value_reg <= pend_reg;
            out_last_reg  <= 1'b0;
            out_empty_reg <= 1'b0;
            out_ovf_reg   <= ovf_reg;
        end else if (cmd.finish) begin
            out_value_reg <= pend_valid_reg ? pend_reg : '0;
            out_last_reg  <= 1'b1;
            out_empty_reg <= !pend_valid_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign stat.scan_last  = (j_reg == fill_reg);
    assign stat.i_last     = ((i_reg + FILL_W'(1)) == fill_reg);
    assign stat.keep       = keep;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;

    assign m_valid       = out_valid_reg;
    assign m_kept_value  = out_value_reg;
    assign m_last_result = out_last_reg;
    assign m_empty_res   = out_empty_reg;
    assign m_overflow    = out_ovf_reg;

endmodule

FILE: rtl/frequency_threshold_filter_top.sv
// Frequency threshold filter. A set of signed 32-bit values arrives one
// transfer per cycle on the s_ channel, the final one marked by s_last_item;
// up to 64 values are stored, further ones are dropped and reported through
// m_overflow on every result of that set. After the final value the block
// emits, in arrival order, each stored value (duplicates included) that
// occurs at least min_count times, with m_last_result on the last one; if
// none qualifies, one result with m_empty_res set and a zero value is given.
// s_ready is low while a set is emitted. Emitting can also stall on the output,
// and it scans the value RAM, which has one read port, once per stored value
// to count its occurrences. Once the final result sits in the output register
// the next set may start loading. The user must write min_count (reset 3)
// through cfg_wr_en/cfg_wr_data only while the block is idle; the block itself
// does not enforce it.
`include "frequency_threshold_filter_top_defines.svh"

module frequency_threshold_filter_top import ftf_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_wr_en,
    input  logic [CNT_W-1:0]          cfg_wr_data,
    // input channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [VALUE_W-1:0] s_value,
    input  logic                      s_last_item,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_kept_value,
    output logic                      m_last_result,
    output logic                      m_empty_res,
    output logic                      m_overflow
);

    // command and status between sequencer and datapath
    ftf_cmd_t  cmd;
    ftf_stat_t stat;

    // sequencer: load, then per stored entry fetch / latch / scan / decide, then finish
    ftf_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_item (s_last_item),
        .s_ready     (s_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // value RAM, counters, pending survivor and output register
    ftf_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_value       (s_value),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kept_value  (m_kept_value),
        .m_last_result (m_last_result),
        .m_empty_res   (m_empty_res),
        .m_overflow    (m_overflow)
    );

    // empty result is always the single, final one with a zero value
    `FTF_ASSERT_NOW(a_empty_form, aclk, aresetn, m_valid && m_empty_res, m_last_result && (m_kept_value == '0), "empty result malformed")

    // after the final transfer is pushed the block is ready to load again
    `FTF_ASSERT_NEXT(a_finish_to_load, aclk, aresetn, cmd.finish, s_ready, "not ready after finish")

    // sequencer issues at most one command per cycle
    `FTF_ASSERT_NOW(a_cmd_onehot, aclk, aresetn, 1'b1, $onehot0(cmd), "overlapping commands")

endmodule

FILE: dv/frequency_threshold_filter_checker.sv
`timescale 1ns / 1ps

module frequency_threshold_filter_checker import ftf_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CNT_W-1:0]          cfg_wr_data,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic signed [VALUE_W-1:0] s_value,
    input  logic                      s_last_item,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [VALUE_W-1:0] m_kept_value,
    input  logic                      m_last_result,
    input  logic                      m_empty_res,
    input  logic                      m_overflow,
    output int                        mismatch_count,
    output int                        pending_results,
    output int                        results_checked
);

    typedef struct packed {
        logic [VALUE_W-1:0] kept_value;
        logic               last_result;
        logic               empty_res;
        logic               overflow;
    } filter_result_t;

    localparam int REPORT_LIMIT = 10;

    // shadow copy of the set being loaded
    logic [VALUE_W-1:0] cell_value [MAX_ITEMS];
    logic [CNT_W-1:0]   cell_count [MAX_ITEMS];
    int                 fill_level;
    logic               dropped;
    logic [CNT_W-1:0]   min_count;

    filter_result_t     expected_results [$];
    int                 errors = 0;
    int                 checked = 0;

    // Count the new value against the stored cells; on the final item
    // queue the surviving cells in arrival order.
    task automatic absorb_value(input logic [VALUE_W-1:0] v, input logic last);
        logic [CNT_W-1:0] hits;
        filter_result_t   res;
        int               kept;
        hits = '0;
        kept = 0;
        if (fill_level < MAX_ITEMS) begin
            for (int i = 0; i < fill_level; i++) begin
                if (cell_value[i] == v) begin
                    cell_count[i] = cell_count[i] + 1'b1;
                    hits          = hits + 1'b1;
                end
            end
            cell_value[fill_level] = v;
            cell_count[fill_level] = hits + 1'b1;
            fill_level++;
        end else begin
            dropped = 1'b1;
        end
        if (last) begin
            for (int i = 0; i < fill_level; i++) begin
                if (cell_count[i] >= min_count) begin
                    res.kept_value  = cell_value[i];
                    res.last_result = 1'b0;
                    res.empty_res   = 1'b0;
                    res.overflow    = dropped;
                    expected_results.push_back(res);
                    kept++;
                end
            end
            if (kept == 0) begin
                res.kept_value  = '0;
                res.last_result = 1'b1;
                res.empty_res   = 1'b1;
                res.overflow    = dropped;
                expected_results.push_back(res);
            end else begin
                res = expected_results.pop_back();
                res.last_result = 1'b1;
                expected_results.push_back(res);
            end
            fill_level = 0;
            dropped    = 1'b0;
        end
    endtask

    task automatic check_result();
        filter_result_t want;
        checked++;
        if (expected_results.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("checker: unexpected result value=%0d last=%0b empty=%0b ovf=%0b",
                         m_kept_value, m_last_result, m_empty_res, m_overflow);
        end else begin
            want = expected_results.pop_front();
            if (want.kept_value !== m_kept_value || want.last_result !== m_last_result ||
                want.empty_res !== m_empty_res || want.overflow !== m_overflow) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("checker: mismatch exp value=%0d last=%0b empty=%0b ovf=%0b, %s",
                             $signed(want.kept_value), want.last_result, want.empty_res,
                             want.overflow,
                             $sformatf("got value=%0d last=%0b empty=%0b ovf=%0b",
                                       m_kept_value, m_last_result, m_empty_res,
                                       m_overflow));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fill_level = 0;
            dropped    = 1'b0;
            min_count  = RESET_MIN_COUNT;
            expected_results.delete();
        end else begin
            if (cfg_wr_en)
                min_count = cfg_wr_data;
            if (s_valid && s_ready)
                absorb_value(s_value, s_last_item);
            if (m_valid && m_ready)
                check_result();
        end
        mismatch_count  <= errors;
        pending_results <= expected_results.size();
        results_checked <= checked;
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ftf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;  // whole run, well above the slowest legal run
    localparam int SETTLE_CYCLES = 16;      // quiet time after the last result of a set
    localparam int TAIL_CYCLES   = 64;      // watch for stray results at the end
    localparam int PHASE_ITEMS   = 20;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_NEG = 32'hFFFF_FFFF;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [CNT_W-1:0]          cfg_wr_data;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [VALUE_W-1:0] s_value;
    logic                      s_last_item;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [VALUE_W-1:0] m_kept_value;
    logic                      m_last_result;
    logic                      m_empty_res;
    logic                      m_overflow;

    int mismatch_count;
    int pending_results;
    int results_checked;

    // idle odds in percent, changed per phase
    int send_idle_pct;
    int recv_idle_pct;

    // run statistics
    int cycle_count   = 0;
    int items_sent    = 0;
    int sets_sent     = 0;
    int dropped_items = 0;
    int cfg_writes    = 0;

    always #5 aclk = ~aclk;

    frequency_threshold_filter_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last_item   (s_last_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kept_value  (m_kept_value),
        .m_last_result (m_last_result),
        .m_empty_res   (m_empty_res),
        .m_overflow    (m_overflow)
    );

    frequency_threshold_filter_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value         (s_value),
        .s_last_item     (s_last_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kept_value    (m_kept_value),
        .m_last_result   (m_last_result),
        .m_empty_res     (m_empty_res),
        .m_overflow      (m_overflow),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: errors");
            $finish;
        end
    end

    // Result side back-pressure, redrawn every cycle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // One input transfer. Random idle cycles go in front of the item only,
    // so valid never drops while an item is offered.
    task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_value     <= v;
        s_last_item <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (last) sets_sent++;
    endtask

    // Drop valid and wait until every queued result has drained, then give
    // the block SETTLE_CYCLES of quiet time to settle back into loading.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // min_count may only change between sets, with nothing in flight.
    task automatic write_min_count(input logic [CNT_W-1:0] val);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cfg_writes++;
    endtask

    // Mostly small thresholds so that sets produce survivors; now and then
    // the edges: zero (all pass), full depth, above depth, all ones.
    function automatic logic [CNT_W-1:0] random_min_count();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CNT_W'(MAX_ITEMS);
            2:       return CNT_W'(MAX_ITEMS + 1);
            3:       return '1;
            default: return CNT_W'($urandom_range(1, 4));
        endcase
    endfunction

    // A set drawn mostly from a small pool of values, so that repeats build
    // counts that reach the threshold; a few items are fully random noise.
    task automatic send_random_set(input int n_items);
        logic signed [VALUE_W-1:0] pool [3];
        logic signed [VALUE_W-1:0] v;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(9))
                0:       pool[k] = VAL_MIN;
                1:       pool[k] = VAL_MAX;
                2:       pool[k] = VAL_NEG;
                3:       pool[k] = '0;
                4:       pool[k] = 1;
                default: pool[k] = $urandom;
            endcase
        end
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(99) < 85)
                v = pool[$urandom_range(2)];
            else
                v = $urandom;
            send_item(v, k == n_items - 1);
        end
        if (n_items > MAX_ITEMS) dropped_items += n_items - MAX_ITEMS;
    endtask

    initial begin
        int phase_start;
        int phase_sets;

        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_value     <= '0;
        s_last_item <= 1'b0;
        send_idle_pct = 16;
        recv_idle_pct = 73;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed sets ----
        // Reset threshold of 3: the most negative value occurs three times.
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_NEG, 1'b0);
        send_item(VAL_MIN, 1'b1);
        // Single item below threshold: only the empty result.
        send_item(5, 1'b1);
        // Threshold zero keeps every stored element.
        write_min_count('0);
        send_item('0, 1'b0);
        send_item(7, 1'b1);
        // Threshold one, one-item set survives.
        write_min_count(CNT_W'(1));
        send_item(VAL_MAX, 1'b1);
        // All ones: no count can reach it.
        write_min_count('1);
        send_item(VAL_NEG, 1'b0);
        send_item(VAL_NEG, 1'b0);
        send_item(VAL_NEG, 1'b1);
        // Threshold equal to the buffer depth.
        write_min_count(CNT_W'(MAX_ITEMS));
        send_item('0, 1'b0);
        send_item('0, 1'b0);
        send_item(1, 1'b1);
        // Interleaved duplicates stay in arrival order.
        write_min_count(CNT_W'(2));
        send_item(VAL_NEG, 1'b0);
        send_item(1, 1'b0);
        send_item(VAL_NEG, 1'b0);
        send_item(1, 1'b0);
        send_item(2, 1'b1);

        // ---- random phases ----
        // phase 0: sender idles a little, receiver a lot
        // phase 1: the other way round
        // phase 2: no idling on either side
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 73;
                end
                1: begin
                    send_idle_pct = 73;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_min_count(random_min_count());
            phase_start = items_sent;
            phase_sets  = 0;
            // One item past a full buffer, carrying the last mark.
            if (phase == 0) send_random_set(MAX_ITEMS + 1);
            // Exactly full, nothing dropped.
            if (phase == 2) send_random_set(MAX_ITEMS);
            while (items_sent - phase_start < PHASE_ITEMS || phase_sets < 2) begin
                if ($urandom_range(3) == 0) write_min_count(random_min_count());
                send_random_set($urandom_range(1, 12));
                phase_sets++;
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run: %0d sets, %0d items (%0d dropped on a full buffer), %0d threshold writes",
                 sets_sent, items_sent, dropped_items, cfg_writes);
        $display("run: %0d results compared, %0d mismatches, %0d cycles",
                 results_checked, mismatch_count, cycle_count);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
